>>> design/cac_pkg.sv
// ----------------------------------------------------------------------------
// Climate actuator controller package
// Shared constants, codes and types for the climate actuator controller.
// ----------------------------------------------------------------------------
package cac_pkg;

   // Sensor and actuator bank sizes.
   localparam int SENSOR_COUNT = 4;
   localparam int UNIT_W       = 4;
   localparam int SENSOR_USED  = (SENSOR_COUNT < UNIT_W) ? SENSOR_COUNT : UNIT_W;

   // Field widths.
   localparam int TEMP_W     = 12;
   localparam int HUM_W      = 10;
   localparam int STATUS_W   = 8;
   localparam int DAY_SEC_W  = 17;
   localparam int MODE_W     = 5;
   localparam int MINUTE_W   = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int ANY_W      = 5;

   // Timer arithmetic.
   localparam int TICK_PERIOD_MS = 100;
   localparam int SEC_PER_MIN    = 60;
   localparam int MS_PER_SEC     = 1000;
   localparam int TIMER_W        = 27;
   localparam int CYCLE_MS_W     = 26;

   // Bit positions inside the mode flags register.
   localparam int FLAG_PER_SENSOR = 2;
   localparam int FLAG_LIGHT      = 3;
   localparam int FLAG_FAN_CYCLE  = 4;

   // Bit positions inside the any-on summary.
   localparam int ANY_FAN    = 0;
   localparam int ANY_HEATER = 1;
   localparam int ANY_PUMP   = 2;
   localparam int ANY_VENT   = 3;
   localparam int ANY_LIGHT  = 4;

   // Reset values of the configuration registers.
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd300;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 12'sd180;
   localparam logic [HUM_W-1:0]         HUM_HIGH_RST  = 10'd800;
   localparam logic [HUM_W-1:0]         HUM_LOW_RST   = 10'd400;
   localparam logic [DAY_SEC_W-1:0]     LIGHT_ON_RST  = DAY_SEC_W'(360 * SEC_PER_MIN);
   localparam logic [DAY_SEC_W-1:0]     LIGHT_OFF_RST = DAY_SEC_W'(1080 * SEC_PER_MIN);

   // Operating mode held in the low two bits of the mode flags.
   typedef enum logic [1:0] {
      MODE_AUTO   = 2'd0,
      MODE_HYBRID = 2'd1,
      MODE_MANUAL = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // Per-sensor status code.
   typedef enum logic [1:0] {
      ST_NORMAL = 2'd0,
      ST_LOW    = 2'd1,
      ST_HIGH   = 2'd2,
      ST_NONE   = 2'd3
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE_FLAGS = 3'd0,
      CSR_TEMP_HIGH  = 3'd1,
      CSR_TEMP_LOW   = 3'd2,
      CSR_HUM_HIGH   = 3'd3,
      CSR_HUM_LOW    = 3'd4,
      CSR_LIGHT_ON   = 3'd5,
      CSR_LIGHT_OFF  = 3'd6,
      CSR_FAN_CYCLE  = 3'd7
   } csr_index_type;

endpackage

>>> design/climate_actuator_controller_unit.sv
// ----------------------------------------------------------------------------
// Climate actuator controller unit
// Drives fan, heater, vent, pump, light and LED outputs from control ticks and failsafe requests.
// ----------------------------------------------------------------------------
// Usage:
// A request on the req_ channel is either a control tick (req_action low)
// or a failsafe request (req_action high). Every request yields one
// response on the rsp_ channel with the actuator bits after that request.
// A request is taken into an input register, evaluated against the
// actuator state and written to the response register once that
// register is free or being drained. One request is accepted per cycle
// while the response side is not stalled; the state update is a single
// pass of compares, a timer add and bit selection between the two
// registers. When the receiver stalls, the response register holds and
// the input register takes one more request; req_ready then drops until
// the response is taken. The csr_ port writes configuration; the user
// must do so only while idle, which the block does not enforce. The fan
// cycle and light window limits are scaled to ms and s at write time.
// Synchronous reset clears the actuator state, the fan cycle timer, both
// channels and restores every configuration register to its default.
// ----------------------------------------------------------------------------
module climate_actuator_controller_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel.
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic signed [cac_pkg::TEMP_W-1:0]       req_mean_temp,
   input  logic [cac_pkg::HUM_W-1:0]               req_avg_hum,
   input  logic                                    req_avg_valid,
   input  logic [cac_pkg::STATUS_W-1:0]            req_temp_status,
   input  logic [cac_pkg::STATUS_W-1:0]            req_hum_status,
   input  logic [cac_pkg::DAY_SEC_W-1:0]           req_day_seconds,
   // Response channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [cac_pkg::UNIT_W-1:0]              rsp_fan_bits,
   output logic [cac_pkg::UNIT_W-1:0]              rsp_heater_bits,
   output logic [cac_pkg::UNIT_W-1:0]              rsp_vent_bits,
   output logic [cac_pkg::UNIT_W-1:0]              rsp_pump_bits,
   output logic                                    rsp_lamps_on,
   output logic                                    rsp_led_on,
   output logic [cac_pkg::ANY_W-1:0]               rsp_any_on,
   // Configuration write port.
   input  logic                                    csr_write_en,
   input  logic [cac_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [cac_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int UW = cac_pkg::UNIT_W;
   localparam int TW = cac_pkg::TIMER_W;

   // Configuration registers.
   logic [cac_pkg::MODE_W-1:0]           mode_flags_ff;
   logic signed [cac_pkg::TEMP_W-1:0]    temp_high_ff;
   logic signed [cac_pkg::TEMP_W-1:0]    temp_low_ff;
   logic [cac_pkg::HUM_W-1:0]            hum_high_ff;
   logic [cac_pkg::HUM_W-1:0]            hum_low_ff;
   logic [cac_pkg::DAY_SEC_W-1:0]        light_on_s_ff;
   logic [cac_pkg::DAY_SEC_W-1:0]        light_off_s_ff;
   logic [cac_pkg::CYCLE_MS_W-1:0]       fan_on_ms_ff;
   logic [cac_pkg::CYCLE_MS_W-1:0]       fan_off_ms_ff;

   // Input register.
   logic                                 hold_valid_ff;
   logic                                 hold_action_ff;
   logic signed [cac_pkg::TEMP_W-1:0]    hold_mean_temp_ff;
   logic [cac_pkg::HUM_W-1:0]            hold_avg_hum_ff;
   logic                                 hold_avg_valid_ff;
   logic [cac_pkg::STATUS_W-1:0]         hold_temp_status_ff;
   logic [cac_pkg::STATUS_W-1:0]         hold_hum_status_ff;
   logic [cac_pkg::DAY_SEC_W-1:0]        hold_day_seconds_ff;

   // Actuator and timer state.
   logic [UW-1:0]                        fan_ff, fan_in;
   logic [UW-1:0]                        heater_ff, heater_in;
   logic [UW-1:0]                        vent_ff, vent_in;
   logic [UW-1:0]                        pump_ff, pump_in;
   logic                                 light_ff, light_in;
   logic                                 led_ff, led_in;
   logic [TW-1:0]                        timer_ff, timer_in;
   logic                                 phase_on_ff, phase_on_in;

   // Response register.
   logic                                 rsp_valid_ff;
   logic [UW-1:0]                        rsp_fan_ff;
   logic [UW-1:0]                        rsp_heater_ff;
   logic [UW-1:0]                        rsp_vent_ff;
   logic [UW-1:0]                        rsp_pump_ff;
   logic                                 rsp_light_ff;
   logic                                 rsp_led_ff;
   logic [cac_pkg::ANY_W-1:0]            rsp_any_ff;
   logic [cac_pkg::ANY_W-1:0]            any_in;

   // Working signals of the evaluation pass.
   cac_pkg::mode_type                    mode;
   cac_pkg::status_type                  temp_st;
   cac_pkg::status_type                  hum_st;
   logic [TW-1:0]                        timer_sum;
   logic                                 eval_fire;
   logic                                 req_take;

   // Handshake: evaluate when the response register is free or draining.
   assign eval_fire = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !hold_valid_ff || eval_fire;
   assign req_take  = req_valid && req_ready;
   assign mode      = cac_pkg::mode_type'(mode_flags_ff[1:0]);

   // Configuration writes; time limits are scaled to seconds and ms here.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_flags_ff  <= '0;
         temp_high_ff   <= cac_pkg::TEMP_HIGH_RST;
         temp_low_ff    <= cac_pkg::TEMP_LOW_RST;
         hum_high_ff    <= cac_pkg::HUM_HIGH_RST;
         hum_low_ff     <= cac_pkg::HUM_LOW_RST;
         light_on_s_ff  <= cac_pkg::LIGHT_ON_RST;
         light_off_s_ff <= cac_pkg::LIGHT_OFF_RST;
         fan_on_ms_ff   <= '0;
         fan_off_ms_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (cac_pkg::csr_index_type'(csr_index))
            cac_pkg::CSR_MODE_FLAGS: begin
               mode_flags_ff <= csr_wdata[cac_pkg::MODE_W-1:0];
            end
            cac_pkg::CSR_TEMP_HIGH: begin
               temp_high_ff <= csr_wdata[cac_pkg::TEMP_W-1:0];
            end
            cac_pkg::CSR_TEMP_LOW: begin
               temp_low_ff <= csr_wdata[cac_pkg::TEMP_W-1:0];
            end
            cac_pkg::CSR_HUM_HIGH: begin
               hum_high_ff <= csr_wdata[cac_pkg::HUM_W-1:0];
            end
            cac_pkg::CSR_HUM_LOW: begin
               hum_low_ff <= csr_wdata[cac_pkg::HUM_W-1:0];
            end
            cac_pkg::CSR_LIGHT_ON: begin
               light_on_s_ff <= cac_pkg::DAY_SEC_W'(
                  csr_wdata[cac_pkg::MINUTE_W-1:0] * cac_pkg::SEC_PER_MIN);
            end
            cac_pkg::CSR_LIGHT_OFF: begin
               light_off_s_ff <= cac_pkg::DAY_SEC_W'(
                  csr_wdata[cac_pkg::MINUTE_W-1:0] * cac_pkg::SEC_PER_MIN);
            end
            cac_pkg::CSR_FAN_CYCLE: begin
               fan_on_ms_ff  <= cac_pkg::CYCLE_MS_W'(
                  csr_wdata[15:0] * cac_pkg::MS_PER_SEC);
               fan_off_ms_ff <= cac_pkg::CYCLE_MS_W'(
                  csr_wdata[31:16] * cac_pkg::MS_PER_SEC);
            end
         endcase
      end
   end

   // Input register: takes a request whenever it is empty or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= req_take || (hold_valid_ff && !eval_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_action_ff      <= req_action;
         hold_mean_temp_ff   <= req_mean_temp;
         hold_avg_hum_ff     <= req_avg_hum;
         hold_avg_valid_ff   <= req_avg_valid;
         hold_temp_status_ff <= req_temp_status;
         hold_hum_status_ff  <= req_hum_status;
         hold_day_seconds_ff <= req_day_seconds;
      end
   end

   // Evaluation pass: next actuator state for the held request.
   always_comb begin
      fan_in      = fan_ff;
      heater_in   = heater_ff;
      vent_in     = vent_ff;
      pump_in     = pump_ff;
      light_in    = light_ff;
      led_in      = led_ff;
      timer_in    = timer_ff;
      phase_on_in = phase_on_ff;
      temp_st     = cac_pkg::ST_NORMAL;
      hum_st      = cac_pkg::ST_NORMAL;
      timer_sum   = timer_ff + TW'(cac_pkg::TICK_PERIOD_MS);

      if (hold_action_ff) begin
         // Failsafe pattern; the cycle timer is left alone.
         heater_in = '0;
         fan_in    = '1;
         vent_in   = '1;
         pump_in   = '0;
         light_in  = 1'b0;
         led_in    = 1'b1;
      end else begin
         // Climate control in automatic and hybrid modes.
         if (mode == cac_pkg::MODE_AUTO || mode == cac_pkg::MODE_HYBRID) begin
            if (mode_flags_ff[cac_pkg::FLAG_PER_SENSOR]) begin
               for (int i = 0; i < cac_pkg::SENSOR_USED; i++) begin
                  temp_st = cac_pkg::status_type'(hold_temp_status_ff[2*i +: 2]);
                  hum_st  = cac_pkg::status_type'(hold_hum_status_ff[2*i +: 2]);
                  if (temp_st == cac_pkg::ST_HIGH) begin
                     fan_in[i]    = 1'b1;
                     heater_in[i] = 1'b0;
                  end else if (temp_st == cac_pkg::ST_LOW) begin
                     heater_in[i] = 1'b1;
                     fan_in[i]    = 1'b0;
                  end
                  if (hum_st == cac_pkg::ST_HIGH) begin
                     vent_in[i] = 1'b1;
                     pump_in[i] = 1'b0;
                  end else if (hum_st == cac_pkg::ST_LOW) begin
                     pump_in[i] = 1'b1;
                     vent_in[i] = 1'b0;
                  end
               end
            end else if (hold_avg_valid_ff) begin
               if (hold_mean_temp_ff >= temp_high_ff) begin
                  fan_in    = '1;
                  heater_in = '0;
               end else if (hold_mean_temp_ff <= temp_low_ff) begin
                  heater_in = '1;
                  fan_in    = '0;
               end
               if (hold_avg_hum_ff >= hum_high_ff) begin
                  vent_in = '1;
                  pump_in = '0;
               end else if (hold_avg_hum_ff <= hum_low_ff) begin
                  pump_in = '1;
                  vent_in = '0;
               end
            end
         end

         // Light window and fan cycle in hybrid and manual modes.
         if (mode == cac_pkg::MODE_HYBRID || mode == cac_pkg::MODE_MANUAL) begin
            if (mode_flags_ff[cac_pkg::FLAG_LIGHT]) begin
               if (light_on_s_ff < light_off_s_ff) begin
                  light_in = (hold_day_seconds_ff >= light_on_s_ff) &&
                             (hold_day_seconds_ff < light_off_s_ff);
               end else begin
                  // The window wraps at midnight, or covers the whole day.
                  light_in = (hold_day_seconds_ff >= light_on_s_ff) ||
                             (hold_day_seconds_ff < light_off_s_ff);
               end
            end
            if (mode_flags_ff[cac_pkg::FLAG_FAN_CYCLE]) begin
               timer_in = timer_sum;
               if (phase_on_ff) begin
                  if (timer_sum >= TW'(fan_on_ms_ff)) begin
                     fan_in      = '0;
                     phase_on_in = 1'b0;
                     timer_in    = '0;
                  end
               end else begin
                  if (timer_sum >= TW'(fan_off_ms_ff)) begin
                     fan_in      = '1;
                     phase_on_in = 1'b1;
                     timer_in    = '0;
                  end
               end
            end
         end
      end

      // Summary of which groups have any unit on.
      any_in                      = '0;
      any_in[cac_pkg::ANY_FAN]    = |fan_in;
      any_in[cac_pkg::ANY_HEATER] = |heater_in;
      any_in[cac_pkg::ANY_PUMP]   = |pump_in;
      any_in[cac_pkg::ANY_VENT]   = |vent_in;
      any_in[cac_pkg::ANY_LIGHT]  = light_in;
   end

   // Actuator state advances once per evaluated request.
   always_ff @(posedge clock) begin
      if (reset) begin
         fan_ff      <= '0;
         heater_ff   <= '0;
         vent_ff     <= '0;
         pump_ff     <= '0;
         light_ff    <= 1'b0;
         led_ff      <= 1'b0;
         timer_ff    <= '0;
         phase_on_ff <= 1'b0;
      end else if (eval_fire) begin
         fan_ff      <= fan_in;
         heater_ff   <= heater_in;
         vent_ff     <= vent_in;
         pump_ff     <= pump_in;
         light_ff    <= light_in;
         led_ff      <= led_in;
         timer_ff    <= timer_in;
         phase_on_ff <= phase_on_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eval_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire) begin
         rsp_fan_ff    <= fan_in;
         rsp_heater_ff <= heater_in;
         rsp_vent_ff   <= vent_in;
         rsp_pump_ff   <= pump_in;
         rsp_light_ff  <= light_in;
         rsp_led_ff    <= led_in;
         rsp_any_ff    <= any_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fan_bits    = rsp_fan_ff;
   assign rsp_heater_bits = rsp_heater_ff;
   assign rsp_vent_bits   = rsp_vent_ff;
   assign rsp_pump_bits   = rsp_pump_ff;
   assign rsp_lamps_on    = rsp_light_ff;
   assign rsp_led_on      = rsp_led_ff;
   assign rsp_any_on      = rsp_any_ff;

endmodule

>>> design/cac_checker.sv
// ----------------------------------------------------------------------------
// Climate actuator controller checker
// Port-level assertions on the controller, bound to the top level.
// ----------------------------------------------------------------------------
module cac_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cac_pkg::UNIT_W-1:0]        rsp_fan_bits,
   input logic [cac_pkg::UNIT_W-1:0]        rsp_heater_bits,
   input logic [cac_pkg::UNIT_W-1:0]        rsp_vent_bits,
   input logic [cac_pkg::UNIT_W-1:0]        rsp_pump_bits,
   input logic                              rsp_lamps_on,
   input logic [cac_pkg::ANY_W-1:0]         rsp_any_on
);

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The summary agrees with the actuator bits of the same response.
   a_any_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_on[cac_pkg::ANY_FAN] == (|rsp_fan_bits)) &&
                    (rsp_any_on[cac_pkg::ANY_HEATER] == (|rsp_heater_bits)) &&
                    (rsp_any_on[cac_pkg::ANY_PUMP] == (|rsp_pump_bits)) &&
                    (rsp_any_on[cac_pkg::ANY_VENT] == (|rsp_vent_bits)) &&
                    (rsp_any_on[cac_pkg::ANY_LIGHT] == rsp_lamps_on))
      else $error("any-on summary does not match actuator bits");

   // With the response side free, a request can always be taken.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request blocked while the response side is free");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind climate_actuator_controller_unit cac_checker u_cac_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_fan_bits    (rsp_fan_bits),
   .rsp_heater_bits (rsp_heater_bits),
   .rsp_vent_bits   (rsp_vent_bits),
   .rsp_pump_bits   (rsp_pump_bits),
   .rsp_lamps_on    (rsp_lamps_on),
   .rsp_any_on      (rsp_any_on)
);

>>> verif/tb_climate_actuator_controller_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Climate actuator controller unit testbench
// Walks a short directed table and then about a thousand random requests
// through the block. Each phase of settings is written while the block is
// idle. Every accepted request is run through a local model of the actuator
// state, and each response is checked field by field against the oldest
// pending prediction. The sender works in bursts and the receiver stalls,
// once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_climate_actuator_controller_unit;

   // Request kinds carried in req_action.
   localparam logic ACT_TICK     = 1'b0;
   localparam logic ACT_FAILSAFE = 1'b1;

   localparam logic [cac_pkg::UNIT_W-1:0] ALL_UNITS = '1;
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 103;
   localparam int PRESSURE_AT      = 450;
   localparam int PRESSURE_CYCLES  = 60;
   localparam int DRAIN_LIMIT      = 5000;

   typedef struct {
      logic                                action;
      logic signed [cac_pkg::TEMP_W-1:0]   mean_temp;
      logic [cac_pkg::HUM_W-1:0]           avg_hum;
      logic                                avg_valid;
      logic [cac_pkg::STATUS_W-1:0]        temp_status;
      logic [cac_pkg::STATUS_W-1:0]        hum_status;
      logic [cac_pkg::DAY_SEC_W-1:0]       day_seconds;
   } climate_req_type;

   typedef struct {
      logic [cac_pkg::UNIT_W-1:0] fan_bits;
      logic [cac_pkg::UNIT_W-1:0] heater_bits;
      logic [cac_pkg::UNIT_W-1:0] vent_bits;
      logic [cac_pkg::UNIT_W-1:0] pump_bits;
      logic                       lamps_on;
      logic                       led_on;
      logic [cac_pkg::ANY_W-1:0]  any_on;
   } actuator_rsp_type;

   typedef struct {
      bit                             is_csr;
      cac_pkg::csr_index_type         idx;
      logic [cac_pkg::CSR_DATA_W-1:0] data;
      climate_req_type                req;
      bit                             typed;
      actuator_rsp_type               want;
   } script_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_action;
   logic signed [cac_pkg::TEMP_W-1:0] req_mean_temp;
   logic [cac_pkg::HUM_W-1:0] req_avg_hum;
   logic req_avg_valid;
   logic [cac_pkg::STATUS_W-1:0] req_temp_status;
   logic [cac_pkg::STATUS_W-1:0] req_hum_status;
   logic [cac_pkg::DAY_SEC_W-1:0] req_day_seconds;
   logic rsp_valid;
   logic rsp_ready;
   logic [cac_pkg::UNIT_W-1:0] rsp_fan_bits;
   logic [cac_pkg::UNIT_W-1:0] rsp_heater_bits;
   logic [cac_pkg::UNIT_W-1:0] rsp_vent_bits;
   logic [cac_pkg::UNIT_W-1:0] rsp_pump_bits;
   logic rsp_lamps_on;
   logic rsp_led_on;
   logic [cac_pkg::ANY_W-1:0] rsp_any_on;
   logic csr_write_en;
   logic [cac_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cac_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Local copy of the settings.
   logic [cac_pkg::MODE_W-1:0]        cfg_mode = '0;
   logic signed [cac_pkg::TEMP_W-1:0] cfg_temp_high = cac_pkg::TEMP_HIGH_RST;
   logic signed [cac_pkg::TEMP_W-1:0] cfg_temp_low = cac_pkg::TEMP_LOW_RST;
   logic [cac_pkg::HUM_W-1:0]         cfg_hum_high = cac_pkg::HUM_HIGH_RST;
   logic [cac_pkg::HUM_W-1:0]         cfg_hum_low = cac_pkg::HUM_LOW_RST;
   logic [cac_pkg::MINUTE_W-1:0]      cfg_light_on = 11'd360;
   logic [cac_pkg::MINUTE_W-1:0]      cfg_light_off = 11'd1080;
   logic [cac_pkg::CSR_DATA_W-1:0]    cfg_fan_cycle = '0;

   // Local copy of the actuator state.
   logic [cac_pkg::UNIT_W-1:0]  fan_on = '0;
   logic [cac_pkg::UNIT_W-1:0]  heater_on = '0;
   logic [cac_pkg::UNIT_W-1:0]  vent_on = '0;
   logic [cac_pkg::UNIT_W-1:0]  pump_on = '0;
   logic                        light_on = 1'b0;
   logic                        led_lit = 1'b0;
   logic [cac_pkg::TIMER_W-1:0] cycle_timer = '0;
   logic                        cycle_phase_on = 1'b0;

   actuator_rsp_type pending_actuator_q[$];
   int unsigned      mismatch_count = 0;
   int unsigned      accepted_count = 0;

   climate_actuator_controller_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_mean_temp(req_mean_temp),
      .req_avg_hum(req_avg_hum),
      .req_avg_valid(req_avg_valid),
      .req_temp_status(req_temp_status),
      .req_hum_status(req_hum_status),
      .req_day_seconds(req_day_seconds),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fan_bits(rsp_fan_bits),
      .rsp_heater_bits(rsp_heater_bits),
      .rsp_vent_bits(rsp_vent_bits),
      .rsp_pump_bits(rsp_pump_bits),
      .rsp_lamps_on(rsp_lamps_on),
      .rsp_led_on(rsp_led_on),
      .rsp_any_on(rsp_any_on),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Applies one request to the local actuator state and returns the
   // response the block should give for it.
   task automatic advance_climate(input climate_req_type r,
                                  output actuator_rsp_type p);
      cac_pkg::mode_type          mode;
      logic [1:0]                 ts;
      logic [1:0]                 hs;
      logic [cac_pkg::UNIT_W-1:0] unit;
      int unsigned                on_s;
      int unsigned                off_s;
      int unsigned                on_ms;
      int unsigned                off_ms;
      int                         i;
      mode = cac_pkg::mode_type'(cfg_mode[1:0]);
      if (r.action == ACT_FAILSAFE) begin
         heater_on = '0;
         fan_on    = ALL_UNITS;
         vent_on   = ALL_UNITS;
         pump_on   = '0;
         light_on  = 1'b0;
         led_lit   = 1'b1;
      end else begin
         // Thermal and humidity control, per sensor or from the averages.
         if (mode == cac_pkg::MODE_AUTO || mode == cac_pkg::MODE_HYBRID) begin
            if (cfg_mode[cac_pkg::FLAG_PER_SENSOR]) begin
               for (i = 0; i < cac_pkg::SENSOR_USED; i++) begin
                  unit = cac_pkg::UNIT_W'(1) << i;
                  ts = r.temp_status[2*i +: 2];
                  hs = r.hum_status[2*i +: 2];
                  if (ts == cac_pkg::ST_HIGH) begin
                     fan_on    = fan_on | unit;
                     heater_on = heater_on & ~unit;
                  end else if (ts == cac_pkg::ST_LOW) begin
                     heater_on = heater_on | unit;
                     fan_on    = fan_on & ~unit;
                  end
                  if (hs == cac_pkg::ST_HIGH) begin
                     vent_on = vent_on | unit;
                     pump_on = pump_on & ~unit;
                  end else if (hs == cac_pkg::ST_LOW) begin
                     pump_on = pump_on | unit;
                     vent_on = vent_on & ~unit;
                  end
               end
            end else if (r.avg_valid) begin
               if (r.mean_temp >= cfg_temp_high) begin
                  fan_on    = ALL_UNITS;
                  heater_on = '0;
               end else if (r.mean_temp <= cfg_temp_low) begin
                  heater_on = ALL_UNITS;
                  fan_on    = '0;
               end
               if (r.avg_hum >= cfg_hum_high) begin
                  vent_on = ALL_UNITS;
                  pump_on = '0;
               end else if (r.avg_hum <= cfg_hum_low) begin
                  pump_on = ALL_UNITS;
                  vent_on = '0;
               end
            end
         end
         if (mode == cac_pkg::MODE_HYBRID || mode == cac_pkg::MODE_MANUAL) begin
            // Light window; a window whose start is not before its end wraps.
            if (cfg_mode[cac_pkg::FLAG_LIGHT]) begin
               on_s  = 32'(cfg_light_on) * cac_pkg::SEC_PER_MIN;
               off_s = 32'(cfg_light_off) * cac_pkg::SEC_PER_MIN;
               if (on_s < off_s)
                  light_on = (r.day_seconds >= on_s) && (r.day_seconds < off_s);
               else
                  light_on = (r.day_seconds >= on_s) || (r.day_seconds < off_s);
            end
            // Fan on/off cycle timer.
            if (cfg_mode[cac_pkg::FLAG_FAN_CYCLE]) begin
               on_ms  = 32'(cfg_fan_cycle[15:0]) * cac_pkg::MS_PER_SEC;
               off_ms = 32'(cfg_fan_cycle[31:16]) * cac_pkg::MS_PER_SEC;
               cycle_timer = cycle_timer +
                             cac_pkg::TIMER_W'(cac_pkg::TICK_PERIOD_MS);
               if (cycle_phase_on) begin
                  if (32'(cycle_timer) >= on_ms) begin
                     fan_on         = '0;
                     cycle_phase_on = 1'b0;
                     cycle_timer    = '0;
                  end
               end else if (32'(cycle_timer) >= off_ms) begin
                  fan_on         = ALL_UNITS;
                  cycle_phase_on = 1'b1;
                  cycle_timer    = '0;
               end
            end
         end
      end
      p.fan_bits    = fan_on;
      p.heater_bits = heater_on;
      p.vent_bits   = vent_on;
      p.pump_bits   = pump_on;
      p.lamps_on    = light_on;
      p.led_on      = led_lit;
      p.any_on      = '0;
      p.any_on[cac_pkg::ANY_FAN]    = |fan_on;
      p.any_on[cac_pkg::ANY_HEATER] = |heater_on;
      p.any_on[cac_pkg::ANY_PUMP]   = |pump_on;
      p.any_on[cac_pkg::ANY_VENT]   = |vent_on;
      p.any_on[cac_pkg::ANY_LIGHT]  = light_on;
   endtask

   function automatic logic [cac_pkg::CSR_DATA_W-1:0] mode_word(
         input cac_pkg::mode_type m, input bit per_sensor,
         input bit light, input bit cycle);
      logic [cac_pkg::CSR_DATA_W-1:0] w;
      w = '0;
      w[1:0] = m;
      w[cac_pkg::FLAG_PER_SENSOR] = per_sensor;
      w[cac_pkg::FLAG_LIGHT] = light;
      w[cac_pkg::FLAG_FAN_CYCLE] = cycle;
      return w;
   endfunction

   function automatic script_row_type csr_row(input cac_pkg::csr_index_type idx,
                                              input logic [cac_pkg::CSR_DATA_W-1:0] data);
      script_row_type row;
      row = '{idx: cac_pkg::CSR_MODE_FLAGS, default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   function automatic script_row_type tick_row(input logic [cac_pkg::TEMP_W-1:0] temp,
                                               input logic [cac_pkg::HUM_W-1:0] hum,
                                               input logic valid,
                                               input logic [cac_pkg::STATUS_W-1:0] tst,
                                               input logic [cac_pkg::STATUS_W-1:0] hst,
                                               input logic [cac_pkg::DAY_SEC_W-1:0] day);
      script_row_type row;
      row = '{idx: cac_pkg::CSR_MODE_FLAGS, default: '0};
      row.req.action = ACT_TICK;
      row.req.mean_temp = temp;
      row.req.avg_hum = hum;
      row.req.avg_valid = valid;
      row.req.temp_status = tst;
      row.req.hum_status = hst;
      row.req.day_seconds = day;
      return row;
   endfunction

   function automatic script_row_type failsafe_row();
      script_row_type row;
      row = tick_row('0, '0, 1'b0, '0, '0, '0);
      row.req.action = ACT_FAILSAFE;
      return row;
   endfunction

   // Attaches a response that can be read off directly.
   function automatic script_row_type with_want(input script_row_type row,
                                                input logic [cac_pkg::UNIT_W-1:0] fan,
                                                input logic [cac_pkg::UNIT_W-1:0] heater,
                                                input logic [cac_pkg::UNIT_W-1:0] vent,
                                                input logic [cac_pkg::UNIT_W-1:0] pump,
                                                input logic lights, input logic led,
                                                input logic [cac_pkg::ANY_W-1:0] any);
      row.typed = 1'b1;
      row.want.fan_bits = fan;
      row.want.heater_bits = heater;
      row.want.vent_bits = vent;
      row.want.pump_bits = pump;
      row.want.lamps_on = lights;
      row.want.led_on = led;
      row.want.any_on = any;
      return row;
   endfunction

   // Writes one register and updates the local copy.
   task automatic write_setting(input cac_pkg::csr_index_type idx,
                                input logic [cac_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         cac_pkg::CSR_MODE_FLAGS: cfg_mode = data[cac_pkg::MODE_W-1:0];
         cac_pkg::CSR_TEMP_HIGH:  cfg_temp_high = data[cac_pkg::TEMP_W-1:0];
         cac_pkg::CSR_TEMP_LOW:   cfg_temp_low = data[cac_pkg::TEMP_W-1:0];
         cac_pkg::CSR_HUM_HIGH:   cfg_hum_high = data[cac_pkg::HUM_W-1:0];
         cac_pkg::CSR_HUM_LOW:    cfg_hum_low = data[cac_pkg::HUM_W-1:0];
         cac_pkg::CSR_LIGHT_ON:   cfg_light_on = data[cac_pkg::MINUTE_W-1:0];
         cac_pkg::CSR_LIGHT_OFF:  cfg_light_off = data[cac_pkg::MINUTE_W-1:0];
         cac_pkg::CSR_FAN_CYCLE:  cfg_fan_cycle = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stops offering requests and waits until every response is back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_actuator_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Offers one request, waits for it to be taken and records its response.
   task automatic offer_request(input climate_req_type r, input bit typed,
                                input actuator_rsp_type typed_rsp);
      actuator_rsp_type predicted;
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_mean_temp   <= r.mean_temp;
      req_avg_hum     <= r.avg_hum;
      req_avg_valid   <= r.avg_valid;
      req_temp_status <= r.temp_status;
      req_hum_status  <= r.hum_status;
      req_day_seconds <= r.day_seconds;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_count++;
      advance_climate(r, predicted);
      pending_actuator_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Random request, mostly close to the current limits and light edges.
   task automatic make_random_request(output climate_req_type r);
      int unsigned pick;
      int unsigned on_s;
      int unsigned off_s;
      r.action = ($urandom_range(0, 19) == 0) ? ACT_FAILSAFE : ACT_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         r.mean_temp = cfg_temp_high - 12'sd3 + cac_pkg::TEMP_W'($urandom_range(0, 6));
      else if (pick < 8)
         r.mean_temp = cfg_temp_low - 12'sd3 + cac_pkg::TEMP_W'($urandom_range(0, 6));
      else if (pick < 9)
         r.mean_temp = cac_pkg::TEMP_W'($urandom_range(0, 1650)) - 12'sd400;
      else
         r.mean_temp = cac_pkg::TEMP_W'($urandom());
      pick = $urandom_range(0, 9);
      if (pick < 4)
         r.avg_hum = cfg_hum_high - 10'd3 + cac_pkg::HUM_W'($urandom_range(0, 6));
      else if (pick < 8)
         r.avg_hum = cfg_hum_low - 10'd3 + cac_pkg::HUM_W'($urandom_range(0, 6));
      else if (pick < 9)
         r.avg_hum = cac_pkg::HUM_W'($urandom_range(0, 1000));
      else
         r.avg_hum = cac_pkg::HUM_W'($urandom());
      r.avg_valid = ($urandom_range(0, 7) != 0);
      r.temp_status = cac_pkg::STATUS_W'($urandom());
      r.hum_status = cac_pkg::STATUS_W'($urandom());
      on_s = 32'(cfg_light_on) * cac_pkg::SEC_PER_MIN;
      off_s = 32'(cfg_light_off) * cac_pkg::SEC_PER_MIN;
      case ($urandom_range(0, 5))
         0: r.day_seconds = cac_pkg::DAY_SEC_W'(on_s - 1);
         1: r.day_seconds = cac_pkg::DAY_SEC_W'(on_s);
         2: r.day_seconds = cac_pkg::DAY_SEC_W'(off_s - 1);
         3: r.day_seconds = cac_pkg::DAY_SEC_W'(off_s);
         4: r.day_seconds = cac_pkg::DAY_SEC_W'($urandom());
         default: r.day_seconds = cac_pkg::DAY_SEC_W'($urandom_range(0, 86399));
      endcase
   endtask

   // Settings for one random phase; the first two use the extremes.
   task automatic choose_settings(input int phase);
      int lo;
      int hi;
      int unsigned on_min;
      int unsigned off_min;
      if (phase == 0) begin
         write_setting(cac_pkg::CSR_MODE_FLAGS,
                       mode_word(cac_pkg::MODE_HYBRID, 1'b1, 1'b1, 1'b1));
         write_setting(cac_pkg::CSR_TEMP_HIGH, 32'h0000_07FF);
         write_setting(cac_pkg::CSR_TEMP_LOW, 32'h0000_0800);
         write_setting(cac_pkg::CSR_HUM_HIGH, 32'h0000_03FF);
         write_setting(cac_pkg::CSR_HUM_LOW, 32'h0000_0000);
         write_setting(cac_pkg::CSR_LIGHT_ON, 32'h0000_0000);
         write_setting(cac_pkg::CSR_LIGHT_OFF, 32'h0000_07FF);
         write_setting(cac_pkg::CSR_FAN_CYCLE, 32'hFFFF_FFFF);
      end else if (phase == 1) begin
         write_setting(cac_pkg::CSR_MODE_FLAGS,
                       32'hFFFF_FFE0 | mode_word(cac_pkg::MODE_AUTO, 1'b0, 1'b1, 1'b1));
         write_setting(cac_pkg::CSR_TEMP_HIGH, 32'(-400));
         write_setting(cac_pkg::CSR_TEMP_LOW, 32'(1250));
         write_setting(cac_pkg::CSR_HUM_HIGH, 32'(0));
         write_setting(cac_pkg::CSR_HUM_LOW, 32'(1000));
         write_setting(cac_pkg::CSR_LIGHT_ON, 32'(1439));
         write_setting(cac_pkg::CSR_LIGHT_OFF, 32'(0));
         write_setting(cac_pkg::CSR_FAN_CYCLE, 32'h0000_0000);
      end else begin
         write_setting(cac_pkg::CSR_MODE_FLAGS,
                       {27'($urandom()), 5'(mode_word(cac_pkg::mode_type'(phase % 4),
                        1'($urandom()), 1'($urandom()), ($urandom_range(0, 3) != 0)))});
         lo = $urandom_range(0, 800) - 400;
         hi = lo + $urandom_range(0, 800);
         if ($urandom_range(0, 4) == 0) begin
            lo = $urandom_range(0, 4095) - 2048;
            hi = $urandom_range(0, 4095) - 2048;
         end
         write_setting(cac_pkg::CSR_TEMP_HIGH, {20'($urandom()), 12'(hi)});
         write_setting(cac_pkg::CSR_TEMP_LOW, {20'($urandom()), 12'(lo)});
         lo = $urandom_range(0, 500);
         hi = lo + $urandom_range(0, 500);
         write_setting(cac_pkg::CSR_HUM_HIGH, {22'($urandom()), 10'(hi)});
         write_setting(cac_pkg::CSR_HUM_LOW, {22'($urandom()), 10'(lo)});
         on_min = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(0, 1439);
         off_min = ($urandom_range(0, 5) == 0) ? on_min : $urandom_range(0, 1439);
         write_setting(cac_pkg::CSR_LIGHT_ON, {21'($urandom()), 11'(on_min)});
         write_setting(cac_pkg::CSR_LIGHT_OFF, {21'($urandom()), 11'(off_min)});
         if (phase == 7)
            write_setting(cac_pkg::CSR_FAN_CYCLE, $urandom());
         else
            write_setting(cac_pkg::CSR_FAN_CYCLE,
                          {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))});
      end
   endtask

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Response checking against the oldest pending prediction.
   always @(posedge clock) begin
      actuator_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_actuator_q.size() == 0) begin
            $display("%0t: response with no request pending, expected none actual fan %0h",
                     $time, rsp_fan_bits);
            mismatch_count++;
         end else begin
            exp_rsp = pending_actuator_q.pop_front();
            check_field("fan_bits", exp_rsp.fan_bits, rsp_fan_bits);
            check_field("heater_bits", exp_rsp.heater_bits, rsp_heater_bits);
            check_field("vent_bits", exp_rsp.vent_bits, rsp_vent_bits);
            check_field("pump_bits", exp_rsp.pump_bits, rsp_pump_bits);
            check_field("lamps_on", exp_rsp.lamps_on, rsp_lamps_on);
            check_field("led_on", exp_rsp.led_on, rsp_led_on);
            check_field("any_on", exp_rsp.any_on, rsp_any_on);
         end
      end
   end

   // Receiver: rotates through stall styles and holds off once for a long
   // stretch so that the block backs up.
   initial begin
      int unsigned cyc;
      bit          pressure_done;
      cyc = 0;
      pressure_done = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!pressure_done && accepted_count >= PRESSURE_AT) begin
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end
         case ((cyc / 48) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((cyc % 5) != 0);
         endcase
         @(posedge clock);
         cyc++;
      end
   end

   // Main stimulus.
   initial begin
      script_row_type   script[$];
      climate_req_type  r;
      actuator_rsp_type unused_rsp;
      int unsigned      burst_left;
      int unsigned      drain;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_action      <= ACT_TICK;
      req_mean_temp   <= '0;
      req_avg_hum     <= '0;
      req_avg_valid   <= 1'b0;
      req_temp_status <= '0;
      req_hum_status  <= '0;
      req_day_seconds <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= cac_pkg::CSR_MODE_FLAGS;
      csr_wdata       <= '0;
      unused_rsp = '{default: '0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Global thresholds with the reset limits, then a failsafe request.
      script.push_back(with_want(tick_row(12'sd0, 10'd0, 1'b1, '0, '0, '0),
                       '0, ALL_UNITS, '0, ALL_UNITS, 1'b0, 1'b0,
                       cac_pkg::ANY_W'((1 << cac_pkg::ANY_HEATER) |
                                       (1 << cac_pkg::ANY_PUMP))));
      script.push_back(with_want(tick_row(12'sd1250, 10'd1000, 1'b1, '0, '0, '0),
                       ALL_UNITS, '0, ALL_UNITS, '0, 1'b0, 1'b0,
                       cac_pkg::ANY_W'((1 << cac_pkg::ANY_FAN) |
                                       (1 << cac_pkg::ANY_VENT))));
      // Invalid averages keep the state.
      script.push_back(with_want(tick_row(-12'sd400, 10'd400, 1'b0, '0, '0, '0),
                       ALL_UNITS, '0, ALL_UNITS, '0, 1'b0, 1'b0,
                       cac_pkg::ANY_W'((1 << cac_pkg::ANY_FAN) |
                                       (1 << cac_pkg::ANY_VENT))));
      script.push_back(tick_row(12'h7FF, 10'h3FF, 1'b1, '1, '1, '1));
      script.push_back(tick_row(12'h800, 10'd0, 1'b1, '0, '0, '0));
      script.push_back(tick_row(12'sd250, 10'd600, 1'b1, '0, '0, '0));
      script.push_back(tick_row(12'sd300, 10'd800, 1'b1, '0, '0, '0));
      script.push_back(tick_row(12'sd180, 10'd400, 1'b1, '0, '0, '0));
      script.push_back(with_want(failsafe_row(), ALL_UNITS, '0, ALL_UNITS, '0, 1'b0, 1'b1,
                       cac_pkg::ANY_W'((1 << cac_pkg::ANY_FAN) |
                                       (1 << cac_pkg::ANY_VENT))));
      // Per-sensor statuses, including normal and unavailable sensors.
      script.push_back(csr_row(cac_pkg::CSR_MODE_FLAGS,
                               mode_word(cac_pkg::MODE_AUTO, 1'b1, 1'b0, 1'b0)));
      script.push_back(tick_row('0, '0, 1'b1,
                       {cac_pkg::ST_NONE, cac_pkg::ST_HIGH, cac_pkg::ST_LOW, cac_pkg::ST_NORMAL},
                       {cac_pkg::ST_NORMAL, cac_pkg::ST_LOW, cac_pkg::ST_HIGH, cac_pkg::ST_NONE},
                       '0));
      script.push_back(tick_row('0, '0, 1'b1, {4{cac_pkg::ST_HIGH}}, {4{cac_pkg::ST_LOW}}, '0));
      script.push_back(tick_row('0, '0, 1'b1, {4{cac_pkg::ST_NONE}},
                                {4{cac_pkg::ST_NORMAL}}, '0));
      script.push_back(tick_row('0, '0, 1'b1, {4{cac_pkg::ST_LOW}}, {4{cac_pkg::ST_HIGH}}, '0));
      // Hybrid with light window and a fan cycle that flips every tick.
      script.push_back(csr_row(cac_pkg::CSR_FAN_CYCLE, 32'h0000_0000));
      script.push_back(csr_row(cac_pkg::CSR_MODE_FLAGS,
                               mode_word(cac_pkg::MODE_HYBRID, 1'b1, 1'b1, 1'b1)));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd0));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd21600));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd64799));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd64800));
      // Window that wraps at midnight.
      script.push_back(csr_row(cac_pkg::CSR_LIGHT_ON, 32'd1380));
      script.push_back(csr_row(cac_pkg::CSR_LIGHT_OFF, 32'd120));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd86399));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'h1FFFF));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd7199));
      // Equal start and end cover the whole day.
      script.push_back(csr_row(cac_pkg::CSR_LIGHT_ON, 32'd600));
      script.push_back(csr_row(cac_pkg::CSR_LIGHT_OFF, 32'd600));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd36000));
      // Manual mode with a one second on phase.
      script.push_back(csr_row(cac_pkg::CSR_FAN_CYCLE, {16'd0, 16'd1}));
      script.push_back(csr_row(cac_pkg::CSR_MODE_FLAGS,
                               mode_word(cac_pkg::MODE_MANUAL, 1'b0, 1'b1, 1'b1)));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd100));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd200));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd300));
      // Light start beyond the last minute of the day.
      script.push_back(csr_row(cac_pkg::CSR_LIGHT_ON, 32'd2047));
      script.push_back(csr_row(cac_pkg::CSR_LIGHT_OFF, 32'd0));
      script.push_back(tick_row('0, '0, 1'b1, '0, '0, 17'd122820));
      // Mode none reports the state unchanged.
      script.push_back(csr_row(cac_pkg::CSR_MODE_FLAGS,
                               mode_word(cac_pkg::MODE_NONE, 1'b1, 1'b1, 1'b1)));
      script.push_back(tick_row(12'h7FF, 10'h3FF, 1'b1, '1, '1, '0));
      script.push_back(failsafe_row());

      foreach (script[k]) begin
         if (script[k].is_csr) begin
            wait_idle();
            write_setting(script[k].idx, script[k].data);
         end else begin
            offer_request(script[k].req, script[k].typed, script[k].want);
         end
      end

      // Random phases, each with fresh settings.
      burst_left = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         choose_settings(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            make_random_request(r);
            offer_request(r, 1'b0, unused_rsp);
         end
      end

      // Drain the remaining responses.
      req_valid <= 1'b0;
      for (drain = 0; drain < DRAIN_LIMIT && pending_actuator_q.size() != 0; drain++)
         @(posedge clock);
      if (pending_actuator_q.size() != 0) begin
         $display("%0t: responses expected %0d actual 0", $time, pending_actuator_q.size());
         mismatch_count += pending_actuator_q.size();
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
